FILE: sv/bitmask_sprite_collision_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sprite collision block
// Concurrent checks share the clock, the reset and the error report.
// ---------------------------------------------------------------------------
`ifndef BITMASK_SPRITE_COLLISION_ASSERT_SVH
`define BITMASK_SPRITE_COLLISION_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsc check failed");

// next-cycle implication, checked outside reset
`define BSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsc check failed");

`endif

FILE: sv/bsc_pkg.sv
// ---------------------------------------------------------------------------
// bsc_pkg
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package bsc_pkg;

  localparam int MaxWordsPerRow = 4;
  localparam int MaxRows        = 256;
  localparam int FrameWords     = MaxRows * MaxWordsPerRow;
  localparam int StoreDepth     = 2 * FrameWords;
  localparam int MaxWidth       = 64 * MaxWordsPerRow;

  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [1:0] REG_WIDTH_A  = 2'd0;
  localparam logic [1:0] REG_HEIGHT_A = 2'd1;
  localparam logic [1:0] REG_WIDTH_B  = 2'd2;
  localparam logic [1:0] REG_HEIGHT_B = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP1,
    ST_SETUP2,
    ST_ISSUE,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;    // request taken this cycle
    logic start;     // capture a query
    logic setup1;    // rectangle bounds
    logic setup2;    // loop limits
    logic issue;     // memory reads and mask
    logic advance;   // next word or row
    logic res_zero;  // no overlap
    logic res_eval;  // take this word's test
    logic out_load;  // present result
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic step_hit;
    logic last_step;
    logic out_free;
  } status_t;

endpackage

FILE: sv/bsc_dp.sv
// ---------------------------------------------------------------------------
// bsc_dp
// Mask stores, config registers, rectangle setup, word walk and AND test.
// ---------------------------------------------------------------------------
module bsc_dp import bsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic [1:0]         kind,
  input  logic               frame_a,
  input  logic               frame_b,
  input  logic [9:0]         word_index,
  input  logic [63:0]        mask_word,
  input  logic signed [15:0] ax,
  input  logic signed [15:0] ay,
  input  logic signed [15:0] bx,
  input  logic signed [15:0] by,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               hit
);

  logic [63:0] mem_a [StoreDepth];
  logic [63:0] mem_b [StoreDepth];

  logic [8:0] width_a, height_a, width_b, height_b;

  // captured query
  logic               fa, fb;
  logic signed [17:0] qax, qay, qbx, qby;

  // setup stage one
  logic signed [17:0] x0, x1, y0, y1;
  logic               zero_dim;
  logic [2:0]         wpra, wprb;
  logic signed [16:0] dx;

  // loop state
  logic [8:0]  lo, hi;
  logic [1:0]  c_lo, c_hi, c;
  logic [7:0]  ra, rb;
  logic [8:0]  rows;
  logic signed [10:0] k_off;
  logic [5:0]  r;

  // issue stage outputs
  logic [63:0] a_q, b0_q, b1_q, m_q;
  logic        b0_ok, b1_ok;
  logic [5:0]  r_q;
  logic        res_q;

  // hold config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_a  <= 9'd64;
      height_a <= 9'd64;
      width_b  <= 9'd64;
      height_b <= 9'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH_A:  width_a  <= cfg_data;
        REG_HEIGHT_A: height_a <= cfg_data;
        REG_WIDTH_B:  width_b  <= cfg_data;
        REG_HEIGHT_B: height_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // write mask words
  always_ff @(posedge clk) begin
    if (cmd.accept && kind == KIND_LOAD_A) mem_a[{frame_a, word_index}] <= mask_word;
    if (cmd.accept && kind == KIND_LOAD_B) mem_b[{frame_b, word_index}] <= mask_word;
  end

  // clamp sizes
  logic [8:0] wa, ha, wb, hb;
  always_comb begin
    wa = (width_a  > 9'(MaxWidth)) ? 9'(MaxWidth) : width_a;
    ha = (height_a > 9'(MaxRows))  ? 9'(MaxRows)  : height_a;
    wb = (width_b  > 9'(MaxWidth)) ? 9'(MaxWidth) : width_b;
    hb = (height_b > 9'(MaxRows))  ? 9'(MaxRows)  : height_b;
  end

  logic signed [17:0] xa_end, xb_end, ya_end, yb_end;
  assign xa_end = qax + $signed({9'd0, wa});
  assign xb_end = qbx + $signed({9'd0, wb});
  assign ya_end = qay + $signed({9'd0, ha});
  assign yb_end = qby + $signed({9'd0, hb});

  logic signed [17:0] lo_full, hi_full;
  logic [8:0]         hi_m1;
  assign lo_full = x0 - qax;
  assign hi_full = x1 - qax;
  assign hi_m1   = hi_full[8:0] - 9'd1;

  // capture query, compute bounds and limits
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      fa  <= frame_a;
      fb  <= frame_b;
      qax <= 18'(ax);
      qay <= 18'(ay);
      qbx <= 18'(bx);
      qby <= 18'(by);
    end
    if (cmd.setup1) begin
      x0 <= (qax > qbx) ? qax : qbx;
      x1 <= (xa_end < xb_end) ? xa_end : xb_end;
      y0 <= (qay > qby) ? qay : qby;
      y1 <= (ya_end < yb_end) ? ya_end : yb_end;
      zero_dim <= (wa == 9'd0) || (ha == 9'd0) || (wb == 9'd0) || (hb == 9'd0);
      wpra <= 3'((wa + 9'd63) >> 6);
      wprb <= 3'((wb + 9'd63) >> 6);
      dx   <= 17'(qax - qbx);
    end
    if (cmd.setup2) begin
      lo    <= lo_full[8:0];
      hi    <= hi_full[8:0];
      c_lo  <= lo_full[7:6];
      c_hi  <= hi_m1[7:6];
      c     <= lo_full[7:6];
      ra    <= 8'(y0 - qay);
      rb    <= 8'(y0 - qby);
      rows  <= 9'(y1 - y0);
      k_off <= 11'(dx >>> 6);
      r     <= dx[5:0];
    end else if (cmd.advance) begin
      if (c == c_hi) begin
        c    <= c_lo;
        ra   <= ra + 8'd1;
        rb   <= rb + 8'd1;
        rows <= rows - 9'd1;
      end else begin
        c <= c + 2'd1;
      end
    end
  end

  assign status.empty = zero_dim || (x0 >= x1) || (y0 >= y1);

  // word addresses and pixel mask
  logic signed [11:0] k0, k1;
  logic               k0_ok, k1_ok;
  logic [10:0]        a_row, b_row;
  logic [9:0]         a_off, b0_off, b1_off;
  logic [8:0]         wl, wr, pl_abs, ph_abs;
  logic [6:0]         pl, ph;

  always_comb begin
    k0     = 12'(k_off) + $signed({10'd0, c});
    k1     = k0 + 12'sd1;
    k0_ok  = !k0[11] && (k0 < $signed({9'd0, wprb}));
    k1_ok  = !k1[11] && (k1 < $signed({9'd0, wprb}));
    a_row  = 11'(ra * wpra);
    b_row  = 11'(rb * wprb);
    a_off  = a_row[9:0] + {8'd0, c};
    b0_off = b_row[9:0] + {8'd0, k0[1:0]};
    b1_off = b_row[9:0] + {8'd0, k1[1:0]};
    wl     = {1'b0, c, 6'd0};
    wr     = wl + 9'd64;
    pl_abs = (lo > wl) ? lo : wl;
    ph_abs = (hi < wr) ? hi : wr;
    pl     = 7'(pl_abs - wl);
    ph     = 7'(ph_abs - wl);
  end

  // read the stores
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      a_q   <= mem_a[{fa, a_off}];
      b0_q  <= mem_b[{fb, b0_off}];
      b1_q  <= mem_b[{fb, b1_off}];
      b0_ok <= k0_ok;
      b1_ok <= k1_ok;
      r_q   <= r;
      m_q   <= ({64{1'b1}} >> pl) & ({64{1'b1}} << (7'd64 - ph));
    end
  end

  // align B and test against A
  logic [63:0] w0, w1, bw;
  always_comb begin
    w0 = b0_ok ? b0_q : 64'd0;
    w1 = b1_ok ? b1_q : 64'd0;
    if (r_q == 6'd0) bw = w0;
    else             bw = (w0 << r_q) | (w1 >> (7'd64 - {1'b0, r_q}));
  end

  assign status.step_hit  = |(a_q & bw & m_q);
  assign status.last_step = (c == c_hi) && (rows == 9'd1);
  assign status.out_free  = !out_valid || !out_stall;

  // hold the answer, then present it
  always_ff @(posedge clk) begin
    if (cmd.res_zero)      res_q <= 1'b0;
    else if (cmd.res_eval) res_q <= status.step_hit;
    if (cmd.out_load) hit <= res_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: sv/bsc_ctrl.sv
// ---------------------------------------------------------------------------
// bsc_ctrl
// Sequencer for query setup, the row and word walk, and result hand-off.
// ---------------------------------------------------------------------------
module bsc_ctrl import bsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] kind,
  output logic       in_stall,
  input  status_t    status,
  output cmd_t       cmd
);

  state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && kind == KIND_QUERY) begin
          cmd.start  = 1'b1;
          state_next = ST_SETUP1;
        end
      end
      ST_SETUP1: begin
        cmd.setup1 = 1'b1;
        state_next = ST_SETUP2;
      end
      ST_SETUP2: begin
        cmd.setup2 = 1'b1;
        if (status.empty) begin
          cmd.res_zero = 1'b1;
          state_next   = ST_DONE;
        end else begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.issue  = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.res_eval = 1'b1;
        if (status.step_hit || status.last_step) begin
          state_next = ST_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/bitmask_sprite_collision.sv
// ---------------------------------------------------------------------------
// bitmask_sprite_collision
// Pixel-exact collision test between two stored 1-bit sprite masks.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries load and query requests. A load
// writes one 64-bit mask word into store A or B; loads are taken one per
// cycle back to back while idle and give no result. A query gives one result
// on the output channel (out_valid/out_stall) with hit. A query walks
// rectangle setup (bounds, then loop limits), then for each overlapped mask
// word a store read and then an align and AND, stopping at the first common
// pixel, then loads the output register; with no overlap it goes from setup
// straight to that load. Input is stalled while a query runs. A finished
// answer waits in the output register while the receiver stalls; loads are
// still taken then, and a next query waits only if its answer would find
// that register full. Config writes (cfg_we/cfg_index/cfg_data) must go in
// only while the block is idle; the block itself does not enforce this.
// Reset sets all four sizes to 64 and empties the output; the mask stores
// are not cleared and every word must be loaded before a query reads it.
// ---------------------------------------------------------------------------
`include "bitmask_sprite_collision_assert.svh"

module bitmask_sprite_collision import bsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic               frame_a,
  input  logic               frame_b,
  input  logic [9:0]         word_index,
  input  logic [63:0]        mask_word,
  input  logic signed [15:0] ax,
  input  logic signed [15:0] ay,
  input  logic signed [15:0] bx,
  input  logic signed [15:0] by,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit
);

  cmd_t    cmd;
  status_t status;

  bsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bsc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (kind),
    .frame_a    (frame_a),
    .frame_b    (frame_b),
    .word_index (word_index),
    .mask_word  (mask_word),
    .ax         (ax),
    .ay         (ay),
    .bx         (bx),
    .by         (by),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .hit        (hit)
  );

  // a query occupies the block
  `BSC_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && kind == KIND_QUERY, in_stall)
  // a result appears only from the done step
  `BSC_ASSERT_NOW(a_out_from_done, $rose(out_valid), $past(cmd.out_load))
  // never load a result over one still waiting
  `BSC_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid || !out_stall)

endmodule
